// ===== design/mlfo_pkg.sv =====
// Shared types, constants and the sine table for the multi-waveform LFO.
`timescale 1ns / 1ps

package mlfo_pkg;

  // Sine table geometry
  localparam int SINE_TABLE_BITS = 10;
  localparam int SINE_FRAC_BITS  = 16 - SINE_TABLE_BITS;
  localparam int SINE_N          = 1 << SINE_TABLE_BITS;
  localparam int SINE_QUARTER    = SINE_N / 4;
  localparam int INTERP_W        = 18 + SINE_FRAC_BITS;
  localparam longint unsigned SINE_SCALE = 64'd32767 * 64'd32;

  typedef logic [SINE_TABLE_BITS-1:0] sine_idx_t;
  typedef logic [SINE_TABLE_BITS-2:0] sine_half_t;
  typedef logic [SINE_TABLE_BITS-3:0] sine_qidx_t;
  typedef logic [14:0] sine_tab_t [SINE_QUARTER];

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_SYNC  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_INC  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_INC  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE = 3'd4;

  // Request opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_SYNC   = 1'b1;

  // Reset values of the configuration registers
  localparam logic [3:0]  RST_WAVEFORM  = 4'd1;
  localparam logic        RST_USE_SYNC  = 1'b0;
  localparam logic [31:0] RST_FREE_INC  = 32'd128849;
  localparam logic [31:0] RST_SYNC_INC  = 32'd8590;
  localparam logic [14:0] RST_AMPLITUDE = 15'd32767;

  // Waveform codes
  localparam logic [3:0] WF_OFF    = 4'd0;
  localparam logic [3:0] WF_SAW    = 4'd1;
  localparam logic [3:0] WF_SINE   = 4'd3;
  localparam logic [3:0] WF_SQUARE = 4'd4;
  localparam logic [3:0] WF_RAMP   = 4'd5;
  localparam logic [3:0] WF_TRAP   = 4'd6;
  localparam logic [3:0] WF_TRI    = 4'd7;
  localparam logic [3:0] WF_STEPS  = 4'd8;
  localparam logic [3:0] WF_FOLD   = 4'd9;

  // Wave shaping constants
  localparam logic [15:0] TRI_OFFSET    = 16'h4000;
  localparam logic [15:0] RAMP_KNEE     = 16'd58982;
  localparam logic [35:0] RAMP_RISE_MUL = 36'd72818;
  localparam logic [35:0] RAMP_FALL_MUL = 36'd655360;
  localparam logic [14:0] AMP_UNITY     = 15'd32767;

  // Queue depths (powers of two, pointers wrap on their own)
  localparam int MQ_DEPTH = 2;
  localparam int MQ_AW    = $clog2(MQ_DEPTH);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);

  typedef struct packed {
    logic [3:0]  waveform;
    logic        use_sync;
    logic [31:0] free_inc;
    logic [31:0] sync_inc;
    logic [14:0] amplitude;
  } cfg_t;

  // One request handed from the front to the back
  typedef struct packed {
    logic [3:0]  waveform;
    logic [15:0] ramp;
  } mid_item_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_ADD
  } front_state_t;

  // Waveforms that advance the phase and produce a shape
  function automatic logic wave_active(logic [3:0] wf);
    return wf inside {WF_SAW, [WF_SINE:WF_FOLD]};
  endfunction

  // One first-quarter table entry, long division done bit by bit
  function automatic logic [14:0] sine_calc(int unsigned k);
    logic [63:0] p;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] rem;
    logic [63:0] quo;
    p   = 64'(k) * 64'(SINE_N - 2 * k);
    num = SINE_SCALE * p;
    den = 64'd5 * 64'(SINE_N) * 64'(SINE_N) - 64'd8 * p;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo[14:0];
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t t;
    for (int k = 0; k < SINE_QUARTER; k++) begin
      t[k] = sine_calc(k + 1);
    end
    return t;
  endfunction

  // Entries 1..N/4 of the first quarter; entry 0 is zero
  localparam sine_tab_t SINE_TAB = build_sine_tab();

  // Full-cycle table read by quarter-wave symmetry
  function automatic logic signed [15:0] sine_at(sine_idx_t idx);
    logic             neg;
    sine_half_t       j;
    sine_half_t       k;
    logic signed [15:0] v;
    neg = idx[SINE_TABLE_BITS-1];
    j   = idx[SINE_TABLE_BITS-2:0];
    k   = (j > sine_half_t'(SINE_QUARTER)) ? sine_half_t'(0) - j : j;
    if (k == sine_half_t'(0)) begin
      v = '0;
    end else begin
      v = $signed({1'b0, SINE_TAB[sine_qidx_t'(k - 1'b1)]});
    end
    return neg ? -v : v;
  endfunction

endpackage

// ===== design/mlfo_front.sv =====
// Front end: takes requests, keeps phase and time reference, forms the ramp.
`timescale 1ns / 1ps

module mlfo_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mlfo_pkg::cfg_t       cfg_i,
  input  logic                 push_i,
  input  logic                 op_i,
  input  logic [31:0]          time_i,
  output logic                 full_o,
  output logic                 q_push_o,
  output mlfo_pkg::mid_item_t  q_item_o,
  input  logic                 q_full_i
);

  mlfo_pkg::front_state_t state_r, state_nxt;

  logic [31:0] phase_r;
  logic [31:0] last_r;
  logic        started_r;
  logic [31:0] dt_r;
  logic [31:0] prod_r;
  logic [31:0] phase_nxt;
  logic [31:0] inc;
  logic        accept;
  logic        active;

  assign accept    = push_i && !full_o;
  assign inc       = cfg_i.use_sync ? cfg_i.sync_inc : cfg_i.free_inc;
  assign active    = mlfo_pkg::wave_active(cfg_i.waveform);
  assign phase_nxt = phase_r + prod_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mlfo_pkg::F_IDLE: begin
        if (push_i && op_i == mlfo_pkg::OP_SAMPLE) state_nxt = mlfo_pkg::F_MUL;
      end
      mlfo_pkg::F_MUL: state_nxt = mlfo_pkg::F_ADD;
      mlfo_pkg::F_ADD: begin
        if (!q_full_i) state_nxt = mlfo_pkg::F_IDLE;
      end
      default: state_nxt = mlfo_pkg::F_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    full_o            = 1'b1;
    q_push_o          = 1'b0;
    q_item_o.waveform = cfg_i.waveform;
    q_item_o.ramp     = active ? phase_nxt[31:16] : phase_r[31:16];
    case (state_r)
      mlfo_pkg::F_IDLE: full_o = 1'b0;
      mlfo_pkg::F_MUL:  full_o = 1'b1;
      mlfo_pkg::F_ADD:  q_push_o = !q_full_i;
      default:          full_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mlfo_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Phase accumulator and time reference
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      last_r    <= '0;
      started_r <= 1'b0;
    end else begin
      if (accept) begin
        last_r    <= time_i;
        started_r <= 1'b1;
        if (op_i == mlfo_pkg::OP_SYNC) begin
          phase_r <= '0;
        end
      end else if (q_push_o && active) begin
        phase_r <= phase_nxt;
      end
    end
  end

  // Elapsed time, then increment times elapsed time (mod 2^32)
  always_ff @(posedge clk) begin
    if (accept) begin
      dt_r <= started_r ? time_i - last_r : '0;
    end
    if (state_r == mlfo_pkg::F_MUL) begin
      prod_r <= inc * dt_r;
    end
  end

endmodule

// ===== design/mlfo_queue.sv =====
// Short queue between front and back end.
`timescale 1ns / 1ps

module mlfo_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_i,
  input  mlfo_pkg::mid_item_t  item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output mlfo_pkg::mid_item_t  item_o,
  output logic                 empty_o
);

  mlfo_pkg::mid_item_t           mem_r [mlfo_pkg::MQ_DEPTH];
  logic [mlfo_pkg::MQ_AW-1:0]    wr_ptr_r;
  logic [mlfo_pkg::MQ_AW-1:0]    rd_ptr_r;
  logic [mlfo_pkg::MQ_AW:0]      cnt_r;
  logic                          do_push;
  logic                          do_pop;

  assign full_o  = (cnt_r == (mlfo_pkg::MQ_AW + 1)'(mlfo_pkg::MQ_DEPTH));
  assign empty_o = (cnt_r == '0);
  assign item_o  = mem_r[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= item_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== design/mlfo_back.sv =====
// Back end: sine interpolation, wave shaping, gain and the result queue.
`timescale 1ns / 1ps

module mlfo_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [14:0]          amp_i,
  input  mlfo_pkg::mid_item_t  q_item_i,
  input  logic                 q_empty_i,
  output logic                 q_pop_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output logic signed [15:0]   sample_o
);

  // Pipeline registers
  logic                       s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic [3:0]                 s1_wf_r, s2_wf_r, s3_wf_r;
  logic [15:0]                s1_ramp_r, s2_ramp_r, s3_ramp_r;
  logic signed [15:0]         s1_y0_r, s2_y0_r, s2_y1_r, s3_sine_r;
  logic signed [15:0]         s4_unit_r;

  // Result queue
  logic signed [15:0]         oq_mem_r [mlfo_pkg::OQ_DEPTH];
  logic [mlfo_pkg::OQ_AW-1:0] oq_wr_r;
  logic [mlfo_pkg::OQ_AW-1:0] oq_rd_r;
  logic [mlfo_pkg::OQ_AW:0]   oq_cnt_r;
  logic                       oq_pop;

  logic [2:0]                 inflight;
  mlfo_pkg::sine_idx_t        idx1_nxt;
  logic signed [16:0]         diff;
  logic signed [mlfo_pkg::INTERP_W-1:0] diff_ext, frac_ext, iprod;
  logic signed [15:0]         sine_nxt;

  logic [15:0]                tri_r0, tri_full;
  logic [14:0]                tri_v;
  logic [35:0]                ramp_p;
  logic signed [17:0]         t18;
  logic signed [18:0]         trap;
  logic signed [17:0]         fold3, fold;
  logic signed [15:0]         unit_nxt;

  logic signed [31:0]         gprod;
  logic signed [31:0]         gshift;
  logic signed [15:0]         gain_out;

  // Admit a request only when the result queue has room for everything in flight
  assign inflight = 3'(s1_vld_r) + 3'(s2_vld_r) + 3'(s3_vld_r) + 3'(s4_vld_r);
  assign q_pop_o  = !q_empty_i &&
                    ((4'(oq_cnt_r) + 4'(inflight)) < 4'(mlfo_pkg::OQ_DEPTH));

  // Linear interpolation between neighboring entries, floor shift
  assign idx1_nxt = s1_ramp_r[15 -: mlfo_pkg::SINE_TABLE_BITS] + mlfo_pkg::sine_idx_t'(1);
  assign diff     = 17'(s2_y1_r) - 17'(s2_y0_r);
  assign diff_ext = mlfo_pkg::INTERP_W'(diff);
  assign frac_ext = $signed({{(mlfo_pkg::INTERP_W - mlfo_pkg::SINE_FRAC_BITS){1'b0}},
                             s2_ramp_r[mlfo_pkg::SINE_FRAC_BITS-1:0]});
  assign iprod    = diff_ext * frac_ext;
  assign sine_nxt = s2_y0_r + 16'(iprod >>> mlfo_pkg::SINE_FRAC_BITS);

  // Triangle core shared by trapezoid, triangle and steps
  assign tri_r0   = s3_ramp_r + mlfo_pkg::TRI_OFFSET;
  assign tri_full = tri_r0[15] ? 16'hFFFF - tri_r0 : tri_r0;
  assign tri_v    = tri_full[14:0];

  // Wave shaping
  always_comb begin
    ramp_p   = '0;
    t18      = '0;
    trap     = '0;
    fold3    = 18'(s3_sine_r) * 18'sd3;
    fold     = fold3 >>> 1;
    unit_nxt = '0;
    case (s3_wf_r)
      mlfo_pkg::WF_SAW:    unit_nxt = $signed(s3_ramp_r);
      mlfo_pkg::WF_SINE:   unit_nxt = s3_sine_r;
      mlfo_pkg::WF_SQUARE: unit_nxt = s3_ramp_r[15] ? -16'sd32767 : 16'sd32767;
      mlfo_pkg::WF_RAMP: begin
        if (s3_ramp_r >= mlfo_pkg::RAMP_KNEE) begin
          ramp_p = 36'(16'hFFFF - s3_ramp_r) * mlfo_pkg::RAMP_FALL_MUL;
        end else begin
          ramp_p = 36'(s3_ramp_r) * mlfo_pkg::RAMP_RISE_MUL;
        end
        t18      = $signed({1'b0, ramp_p[32:16]}) - 18'sd32767;
        unit_nxt = 16'(t18);
      end
      mlfo_pkg::WF_TRAP: begin
        trap = $signed({4'b0, tri_v}) * 19'sd6 - 19'sd98304;
        if (trap > 19'sd32767) begin
          unit_nxt = 16'sd32767;
        end else if (trap < -19'sd32767) begin
          unit_nxt = -16'sd32767;
        end else begin
          unit_nxt = 16'(trap);
        end
      end
      mlfo_pkg::WF_TRI: begin
        t18      = $signed({2'b0, tri_v, 1'b0}) - 18'sd32768;
        unit_nxt = 16'(t18);
      end
      mlfo_pkg::WF_STEPS: begin
        t18      = $signed(18'(tri_v[14:12]) * 18'd9362) - 18'sd32767;
        unit_nxt = 16'(t18);
      end
      mlfo_pkg::WF_FOLD: begin
        if (fold > 18'sd32767) begin
          unit_nxt = 16'(18'sd65534 - fold);
        end else if (fold < -18'sd32767) begin
          unit_nxt = 16'(-18'sd65534 - fold);
        end else begin
          unit_nxt = 16'(fold);
        end
      end
      default: unit_nxt = '0;
    endcase
  end

  // Q15 gain with clamp; unity passes the wave unchanged
  assign gprod  = 32'(s4_unit_r) * $signed({17'b0, amp_i});
  assign gshift = gprod >>> 15;
  always_comb begin
    if (amp_i == '0) begin
      gain_out = '0;
    end else if (amp_i == mlfo_pkg::AMP_UNITY) begin
      gain_out = s4_unit_r;
    end else if (gshift > 32'sd32767) begin
      gain_out = 16'sd32767;
    end else if (gshift < -32'sd32767) begin
      gain_out = -16'sd32767;
    end else begin
      gain_out = 16'(gshift);
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= q_pop_o;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    s1_wf_r   <= q_item_i.waveform;
    s1_ramp_r <= q_item_i.ramp;
    s1_y0_r   <= mlfo_pkg::sine_at(q_item_i.ramp[15 -: mlfo_pkg::SINE_TABLE_BITS]);
    s2_wf_r   <= s1_wf_r;
    s2_ramp_r <= s1_ramp_r;
    s2_y0_r   <= s1_y0_r;
    s2_y1_r   <= mlfo_pkg::sine_at(idx1_nxt);
    s3_wf_r   <= s2_wf_r;
    s3_ramp_r <= s2_ramp_r;
    s3_sine_r <= sine_nxt;
    s4_unit_r <= unit_nxt;
  end

  // Result queue
  assign empty_o  = (oq_cnt_r == '0);
  assign sample_o = oq_mem_r[oq_rd_r];
  assign oq_pop   = pop_i && !empty_o;

  always_ff @(posedge clk) begin
    if (s4_vld_r) oq_mem_r[oq_wr_r] <= gain_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (s4_vld_r) oq_wr_r <= oq_wr_r + 1'b1;
      if (oq_pop)   oq_rd_r <= oq_rd_r + 1'b1;
      if (s4_vld_r && !oq_pop) begin
        oq_cnt_r <= oq_cnt_r + 1'b1;
      end else if (!s4_vld_r && oq_pop) begin
        oq_cnt_r <= oq_cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== design/multi_waveform_lfo.sv =====
// Top level: configuration registers and the front, queue and back end.
// A sample request keeps the front end busy through its accept / multiply / accumulate
//   sequence, whose accumulate step waits while the queue is full; a sync request does not.
// Reset (rst_n low, synchronous): phase, time reference and started flag
//   cleared, registers to their defaults, queues empty; no clearing pass.
`timescale 1ns / 1ps

module multi_waveform_lfo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic                          in_op,
  input  logic [31:0]                   in_time_us,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [15:0]            out_sample,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mlfo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  mlfo_pkg::cfg_t      cfg_r;
  mlfo_pkg::mid_item_t f_item, b_item;
  logic                f_push, q_full, q_empty, b_pop;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.waveform  <= mlfo_pkg::RST_WAVEFORM;
      cfg_r.use_sync  <= mlfo_pkg::RST_USE_SYNC;
      cfg_r.free_inc  <= mlfo_pkg::RST_FREE_INC;
      cfg_r.sync_inc  <= mlfo_pkg::RST_SYNC_INC;
      cfg_r.amplitude <= mlfo_pkg::RST_AMPLITUDE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mlfo_pkg::CFG_WAVEFORM:  cfg_r.waveform  <= cfg_data[3:0];
        mlfo_pkg::CFG_USE_SYNC:  cfg_r.use_sync  <= cfg_data[0];
        mlfo_pkg::CFG_FREE_INC:  cfg_r.free_inc  <= cfg_data;
        mlfo_pkg::CFG_SYNC_INC:  cfg_r.sync_inc  <= cfg_data;
        mlfo_pkg::CFG_AMPLITUDE: cfg_r.amplitude <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  mlfo_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_i    (cfg_r),
    .push_i   (push),
    .op_i     (in_op),
    .time_i   (in_time_us),
    .full_o   (full),
    .q_push_o (f_push),
    .q_item_o (f_item),
    .q_full_i (q_full)
  );

  mlfo_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (f_push),
    .item_i  (f_item),
    .full_o  (q_full),
    .pop_i   (b_pop),
    .item_o  (b_item),
    .empty_o (q_empty)
  );

  mlfo_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .amp_i     (cfg_r.amplitude),
    .q_item_i  (b_item),
    .q_empty_i (q_empty),
    .q_pop_o   (b_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .sample_o  (out_sample)
  );

endmodule

// ===== design/mlfo_checker.sv =====
// Port-level checks for the LFO, bound to the top level.
`timescale 1ns / 1ps

module mlfo_props (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          push,
  input logic                          full,
  input logic                          in_op,
  input logic                          empty,
  input logic                          pop,
  input logic signed [15:0]            out_sample
);

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result pending after reset");

  // A sample request keeps the front busy for its multiply
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    push && !full && in_op == mlfo_pkg::OP_SAMPLE |=> full)
    else $error("front accepted during phase update");

  // A sync request completes in the accepting cycle
  a_sync_free: assert property (@(posedge clk) disable iff (!rst_n)
    push && !full && in_op == mlfo_pkg::OP_SYNC |=> !full)
    else $error("sync request stalled the input");

  // A waiting result stays put until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_sample))
    else $error("waiting result changed or vanished");

endmodule

bind multi_waveform_lfo mlfo_props u_mlfo_props (.*);
